@@ sv/pcc_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and types of the path canonicalize check block
package pcc_pkg;

   localparam int PATH_LEN    = 63;
   localparam int PTR_W       = 6;
   localparam int LEVEL_MAX   = 63;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_LONG   = 2'd2;

   typedef enum logic [1:0] {
      OP_KEEP,
      OP_DROP,
      OP_REJECT,
      OP_END
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
      logic        inc;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } op_chan_type;

endpackage

@@ sv/pcc_queue.sv @@
`timescale 1ns / 1ps
// small operation queue between the classifier and the executor
module pcc_queue (
   input  logic                clock,
   input  logic                reset,
   input  pcc_pkg::op_chan_type push,
   output logic                push_ready,
   output pcc_pkg::op_chan_type pop,
   input  logic                pop_ready
);

   pcc_pkg::op_type                entry_ff [pcc_pkg::QUEUE_DEPTH];
   logic [pcc_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pcc_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pcc_pkg::QPTR_W:0]       count_ff, count_in;
   logic                           do_push, do_pop;

   assign push_ready = count_ff != (pcc_pkg::QPTR_W+1)'(pcc_pkg::QUEUE_DEPTH);
   assign pop.valid  = count_ff != '0;
   assign pop.op     = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + pcc_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + pcc_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (pcc_pkg::QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (pcc_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.op;
      end
   end

endmodule

@@ sv/pcc_front.sv @@
`timescale 1ns / 1ps
// request intake and lookahead classifier that issues store operations
module pcc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // path_byte
   output pcc_pkg::op_chan_type push,
   input  logic                 push_ready
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_RUN,
      F_SKIP,
      F_END
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] wb_ff [4];
   logic [7:0] wb_in [4];
   logic [2:0] cnt_ff, cnt_in;
   logic       zero_ff, zero_in;

   always_comb begin
      state_in   = state_ff;
      wb_in      = wb_ff;
      cnt_in     = cnt_ff;
      zero_in    = zero_ff;
      req_tready = 1'b0;
      push       = '0;
      unique case (state_ff)
         F_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               wb_in[cnt_ff[1:0]] = req_tdata;
               cnt_in             = cnt_ff + 3'd1;
               zero_in            = req_tdata == pcc_pkg::CH_NUL;
               state_in           = F_RUN;
            end
         end
         F_RUN: begin
            if (cnt_ff == 3'd0) begin
               state_in = F_IDLE;
            end else if (wb_ff[0] != pcc_pkg::CH_SLASH) begin
               push.valid = 1'b1;
               if (wb_ff[0] == pcc_pkg::CH_NUL) begin
                  push.op.kind = pcc_pkg::OP_END;
                  if (push_ready) begin
                     cnt_in   = 3'd0;
                     state_in = F_IDLE;
                  end
               end else begin
                  push.op.kind = pcc_pkg::OP_KEEP;
                  push.op.data = wb_ff[0];
                  if (push_ready) begin
                     for (int i = 0; i < 3; i++) begin
                        wb_in[i] = wb_ff[i+1];
                     end
                     cnt_in = cnt_ff - 3'd1;
                  end
               end
            end else if (cnt_ff < 3'd2) begin
               state_in = F_IDLE;
            end else if (wb_ff[1] == pcc_pkg::CH_SLASH
                         || (wb_ff[1] == pcc_pkg::CH_DOT && cnt_ff >= 3'd3
                             && wb_ff[2] == pcc_pkg::CH_SLASH)) begin
               // doubled slash or slash-dot-slash
               push.valid   = 1'b1;
               push.op.kind = pcc_pkg::OP_REJECT;
               if (push_ready) begin
                  cnt_in   = 3'd0;
                  state_in = zero_ff ? F_END : F_SKIP;
               end
            end else if (wb_ff[1] == pcc_pkg::CH_DOT && cnt_ff < 3'd3) begin
               state_in = F_IDLE;
            end else if (wb_ff[1] == pcc_pkg::CH_DOT && wb_ff[2] == pcc_pkg::CH_DOT
                         && cnt_ff < 3'd4) begin
               state_in = F_IDLE;
            end else if (wb_ff[1] == pcc_pkg::CH_DOT && wb_ff[2] == pcc_pkg::CH_DOT
                         && wb_ff[3] == pcc_pkg::CH_SLASH) begin
               // parent step, trailing slash stays for the next decision
               push.valid   = 1'b1;
               push.op.kind = pcc_pkg::OP_DROP;
               if (push_ready) begin
                  wb_in[0] = wb_ff[3];
                  cnt_in   = cnt_ff - 3'd3;
               end
            end else begin
               push.valid   = 1'b1;
               push.op.kind = pcc_pkg::OP_KEEP;
               push.op.data = pcc_pkg::CH_SLASH;
               push.op.inc  = 1'b1;
               if (push_ready) begin
                  for (int i = 0; i < 3; i++) begin
                     wb_in[i] = wb_ff[i+1];
                  end
                  cnt_in = cnt_ff - 3'd1;
               end
            end
         end
         F_SKIP: begin
            req_tready = push_ready;
            if (req_tvalid && req_tdata == pcc_pkg::CH_NUL) begin
               push.valid   = 1'b1;
               push.op.kind = pcc_pkg::OP_END;
               if (push_ready) begin
                  state_in = F_IDLE;
               end
            end
         end
         F_END: begin
            push.valid   = 1'b1;
            push.op.kind = pcc_pkg::OP_END;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         zero_ff  <= zero_in;
      end
      wb_ff <= wb_in;
   end

endmodule

@@ sv/pcc_back.sv @@
`timescale 1ns / 1ps
// operation executor with path store, parent search and response emission
module pcc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pcc_pkg::op_chan_type pop,
   output logic                 pop_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // out_byte, status, slash_count
   output logic                 rsp_tlast    // last
);

   typedef enum logic [2:0] {
      B_IDLE,
      B_DROP_RD,
      B_DROP_CHK,
      B_EMIT_RD,
      B_EMIT_WR,
      B_FINAL
   } state_type;

   state_type                  state_ff, state_in;
   logic [pcc_pkg::PTR_W-1:0]  wp_ff, wp_in;
   logic [pcc_pkg::PTR_W-1:0]  level_ff, level_in;
   logic [pcc_pkg::PTR_W-1:0]  ptr_ff, ptr_in;
   logic                       reject_ff, reject_in;
   logic                       overflow_ff, overflow_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [15:0]                rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [7:0]                 store_ff [pcc_pkg::PATH_LEN];
   logic [7:0]                 rd_data_ff;
   logic                       we, rd_en;
   logic [pcc_pkg::PTR_W-1:0]  rd_addr;

   logic                       faulted, out_free;
   logic [1:0]                 status;

   assign faulted    = reject_ff || overflow_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign status     = overflow_ff ? pcc_pkg::ST_LONG
                     : (reject_ff ? pcc_pkg::ST_REJECT : pcc_pkg::ST_OK);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      level_in     = level_ff;
      ptr_in       = ptr_ff;
      reject_in    = reject_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      pop_ready    = 1'b0;
      we           = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      unique case (state_ff)
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop.valid) begin
               unique case (pop.op.kind)
                  pcc_pkg::OP_KEEP: begin
                     if (!faulted) begin
                        if (pop.op.inc && level_ff != pcc_pkg::PTR_W'(pcc_pkg::LEVEL_MAX)) begin
                           level_in = level_ff + pcc_pkg::PTR_W'(1);
                        end
                        if (wp_ff == pcc_pkg::PTR_W'(pcc_pkg::PATH_LEN)) begin
                           overflow_in = 1'b1;
                        end else begin
                           we    = 1'b1;
                           wp_in = wp_ff + pcc_pkg::PTR_W'(1);
                        end
                     end
                  end
                  pcc_pkg::OP_DROP: begin
                     if (!faulted) begin
                        ptr_in   = wp_ff;
                        state_in = B_DROP_RD;
                     end
                  end
                  pcc_pkg::OP_REJECT: begin
                     if (!faulted) begin
                        reject_in = 1'b1;
                     end
                  end
                  pcc_pkg::OP_END: begin
                     if (!faulted && wp_ff != '0) begin
                        ptr_in   = '0;
                        state_in = B_EMIT_RD;
                     end else begin
                        state_in = B_FINAL;
                     end
                  end
               endcase
            end
         end
         B_DROP_RD: begin
            // walk back toward the nearest kept slash
            if (ptr_ff == '0) begin
               reject_in = 1'b1;
               state_in  = B_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ptr_ff - pcc_pkg::PTR_W'(1);
               ptr_in   = ptr_ff - pcc_pkg::PTR_W'(1);
               state_in = B_DROP_CHK;
            end
         end
         B_DROP_CHK: begin
            if (rd_data_ff == pcc_pkg::CH_SLASH) begin
               wp_in    = ptr_ff;
               state_in = B_IDLE;
            end else begin
               state_in = B_DROP_RD;
            end
         end
         B_EMIT_RD: begin
            rd_en    = 1'b1;
            state_in = B_EMIT_WR;
         end
         B_EMIT_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, pcc_pkg::ST_OK, rd_data_ff};
               rsp_last_in  = 1'b0;
               ptr_in       = ptr_ff + pcc_pkg::PTR_W'(1);
               state_in     = (ptr_ff + pcc_pkg::PTR_W'(1) == wp_ff) ? B_FINAL : B_EMIT_RD;
            end
         end
         B_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(status == pcc_pkg::ST_OK) ? level_ff : 6'd0, status,
                               pcc_pkg::CH_NUL};
               rsp_last_in  = 1'b1;
               wp_in        = '0;
               level_in     = '0;
               reject_in    = 1'b0;
               overflow_in  = 1'b0;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         wp_ff        <= '0;
         level_ff     <= '0;
         ptr_ff       <= '0;
         reject_ff    <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         level_ff     <= level_in;
         ptr_ff       <= ptr_in;
         reject_ff    <= reject_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // path store
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[wp_ff] <= pop.op.data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

endmodule

@@ sv/path_canonicalize_check_core.sv @@
`timescale 1ns / 1ps
// path canonicalize check top level: classifier, operation queue and executor
// flow: a decided byte passes the lookahead buffer and the operation queue to the path
//    store; a parent step searches the store back one entry per read and check pair;
//    after the terminator each kept byte is read and emitted, then one final response
// intake: the front accepts a request byte, makes each decision, then returns to idle;
//    a parent search or the emission stalls intake once the 4-entry queue fills
// reset: synchronous active high, clears all control state; no clearing pass
module path_canonicalize_check_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // path_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte, status, slash_count
   output logic        rsp_tlast    // last
);

   pcc_pkg::op_chan_type q_push, q_pop;
   logic                 q_push_ready, q_pop_ready;

   pcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (q_push),
      .push_ready (q_push_ready)
   );

   pcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ready (q_push_ready),
      .pop        (q_pop),
      .pop_ready  (q_pop_ready)
   );

   pcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (q_pop),
      .pop_ready  (q_pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_final_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == pcc_pkg::CH_NUL)
      else $error("final response carries a nonzero byte");

   a_byte_no_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[15:8] == 8'd0)
      else $error("byte response carries status or count");

   a_fault_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp_tdata[9:8] != pcc_pkg::ST_OK
      |-> rsp_tdata[15:10] == 6'd0)
      else $error("faulted path reports a slash count");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:8] != 2'b11)
      else $error("undefined status code");

endmodule

@@ dv/path_canon_checker.sv @@
`timescale 1ns / 1ps
// checker for the path canonicalize check block: predicts results per request and compares
module path_canon_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // path_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // out_byte, status, slash_count
   input  logic        rsp_tlast,   // last
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
      logic [5:0] slashes;
      logic       last;
   } result_type;

   logic [7:0]   hold [3];
   int unsigned  hold_fill;
   logic [7:0]   canon [pcc_pkg::PATH_LEN];
   int unsigned  canon_len;
   int unsigned  levels;
   bit           rejected;
   bit           too_long;
   result_type   canon_q [$];

   function automatic void store_byte(input logic [7:0] b);
      if (canon_len >= pcc_pkg::PATH_LEN) begin
         too_long = 1'b1;
      end else begin
         canon[canon_len] = b;
         canon_len++;
      end
   endfunction

   // terminator seen: queue the canonical bytes (only for an accepted path) and the final item, then start over
   task automatic close_path();
      result_type r;
      logic [1:0] st;
      st = too_long ? pcc_pkg::ST_LONG : (rejected ? pcc_pkg::ST_REJECT : pcc_pkg::ST_OK);
      if (st == pcc_pkg::ST_OK) begin
         for (int k = 0; k < canon_len; k++) begin
            r = '{out_byte: canon[k], status: pcc_pkg::ST_OK, slashes: 6'd0, last: 1'b0};
            canon_q.push_back(r);
         end
      end
      r = '{out_byte: pcc_pkg::CH_NUL, status: st,
            slashes: (st == pcc_pkg::ST_OK) ? 6'(levels) : 6'd0, last: 1'b1};
      canon_q.push_back(r);
      hold_fill = 0;
      canon_len = 0;
      levels    = 0;
      rejected  = 1'b0;
      too_long  = 1'b0;
   endtask

   task automatic accept_byte(input logic [7:0] c);
      logic [7:0]  w [4];
      int unsigned n;
      int unsigned pos;
      int unsigned avail;
      int          j;
      bit          found;
      bit          ended;
      if (rejected || too_long) begin
         if (c == pcc_pkg::CH_NUL) close_path();
         return;
      end
      n = hold_fill;
      for (int i = 0; i < n; i++) w[i] = hold[i];
      w[n] = c;
      n++;
      pos   = 0;
      ended = 1'b0;
      while (pos < n) begin
         avail = n - pos;
         if (w[pos] != pcc_pkg::CH_SLASH) begin
            if (w[pos] == pcc_pkg::CH_NUL) begin
               ended = 1'b1;
               break;
            end
            store_byte(w[pos]);
            if (too_long) break;
            pos++;
            continue;
         end
         if (avail < 2) break;
         if (w[pos+1] == pcc_pkg::CH_SLASH) begin
            rejected = 1'b1;
            break;
         end
         if (w[pos+1] == pcc_pkg::CH_DOT) begin
            if (avail < 3) break;
            if (w[pos+2] == pcc_pkg::CH_SLASH) begin
               rejected = 1'b1;
               break;
            end
            if (w[pos+2] == pcc_pkg::CH_DOT) begin
               if (avail < 4) break;
               if (w[pos+3] == pcc_pkg::CH_SLASH) begin
                  // parent step: cut back to the nearest kept slash
                  found = 1'b0;
                  for (j = int'(canon_len) - 1; j >= 0 && !found; j--) begin
                     if (canon[j] == pcc_pkg::CH_SLASH) begin
                        canon_len = j;
                        found     = 1'b1;
                     end
                  end
                  if (!found) begin
                     rejected = 1'b1;
                     break;
                  end
                  pos += 3;
                  continue;
               end
            end
         end
         if (levels < pcc_pkg::LEVEL_MAX) levels++;
         store_byte(pcc_pkg::CH_SLASH);
         if (too_long) break;
         pos++;
      end
      if (ended) begin
         close_path();
      end else if (rejected || too_long) begin
         hold_fill = 0;
         if (c == pcc_pkg::CH_NUL) close_path();
      end else begin
         hold_fill = 0;
         for (int i = pos; i < n && hold_fill < 3; i++) begin
            hold[hold_fill] = w[i];
            hold_fill++;
         end
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         hold_fill = 0;
         canon_len = 0;
         levels    = 0;
         rejected  = 1'b0;
         too_long  = 1'b0;
         canon_q.delete();
         errors  = 0;
         pending = 0;
      end else begin
         if (req_tvalid && req_tready) accept_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = '{out_byte: rsp_tdata[7:0], status: rsp_tdata[9:8],
                    slashes: rsp_tdata[15:10], last: rsp_tlast};
            if (canon_q.size() == 0) begin
               $display("%0t: unexpected result byte %02h status %0d count %0d last %0d",
                        $time, got.out_byte, got.status, got.slashes, got.last);
               errors++;
            end else begin
               want = canon_q.pop_front();
               if (got.out_byte !== want.out_byte || got.status !== want.status ||
                   got.slashes !== want.slashes || got.last !== want.last) begin
                  // byte/status/count/last
                  $display("%0t: mismatch, expected %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                           $time, want.out_byte, want.status, want.slashes, want.last,
                           got.out_byte, got.status, got.slashes, got.last);
                  errors++;
               end
            end
         end
         pending = canon_q.size();
      end
   end

endmodule

@@ dv/tb_path_canonicalize_check_core.sv @@
`timescale 1ns / 1ps
// testbench top for the path canonicalize check block: stimulus, idling, watchdog, verdict
module tb_path_canonicalize_check_core;

   typedef logic [7:0] path_type [$];

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 300;
   localparam int RANDOM_BYTES = 250;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   int          errors;
   int          pending;
   int          idle_pct  = 0;
   int          stall_pct = 0;
   int          sent      = 0;
   int          npath     = 0;
   int          quiet     = 0;

   path_canonicalize_check_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   path_canon_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .errors     (errors),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic path_type text_path(input string s);
      path_type p;
      for (int i = 0; i < s.len(); i++) p.push_back(s[i]);
      return p;
   endfunction

   // each parent step after the first component adds one level and keeps the path short
   function automatic path_type deep_path(input int reps);
      path_type p;
      path_type tail;
      p    = text_path("/a");
      tail = text_path("/../a");
      repeat (reps) foreach (tail[i]) p.push_back(tail[i]);
      return p;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send_path(input path_type p);
      case ((npath / 2) % 4)
         0: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         1: begin
            idle_pct  = 61;
            stall_pct = 0;
         end
         2: begin
            idle_pct  = 0;
            stall_pct = 61;
         end
         default: begin
            idle_pct  = 13;
            stall_pct = 13;
         end
      endcase
      foreach (p[i]) send_byte(p[i]);
      send_byte(pcc_pkg::CH_NUL);
      npath++;
   endtask

   initial begin
      path_type   p;
      int         kind;
      int         ncomp;
      int         pick;
      int         len;
      bit         lead;
      logic [7:0] b;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed paths
      send_path(text_path(""));
      p    = text_path("/x/../y");
      p[1] = 8'hFF;
      p[6] = 8'h01;
      send_path(p);
      send_path(text_path("a//x"));
      send_path(text_path("/./"));
      send_path(text_path("/.."));
      send_path(text_path("a/../"));

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      send_path(deep_path(8));

      while (sent < RANDOM_BYTES) begin
         p.delete();
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            ncomp = $urandom_range(1, 6);
            lead  = ($urandom_range(0, 3) != 0);
            for (int c = 0; c < ncomp; c++) begin
               if (c > 0 || lead) p.push_back(pcc_pkg::CH_SLASH);
               pick = $urandom_range(0, 19);
               if (pick == 0) begin
                  p.push_back(pcc_pkg::CH_DOT);
               end else if (pick < 3) begin
                  p.push_back(pcc_pkg::CH_DOT);
                  p.push_back(pcc_pkg::CH_DOT);
               end else begin
                  len = $urandom_range(1, 5);
                  repeat (len) begin
                     if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(1, 255));
                     else b = 8'(8'h61 + $urandom_range(0, 25));
                     if (b == pcc_pkg::CH_SLASH) b = pcc_pkg::CH_DOT;
                     p.push_back(b);
                  end
               end
            end
            if ($urandom_range(0, 4) == 0) p.push_back(pcc_pkg::CH_SLASH);
         end else if (kind < 85) begin
            len = $urandom_range(1, 12);
            repeat (len) begin
               pick = $urandom_range(0, 2);
               if (pick == 0) p.push_back(pcc_pkg::CH_SLASH);
               else if (pick == 1) p.push_back(pcc_pkg::CH_DOT);
               else p.push_back(8'($urandom_range(1, 255)));
            end
         end else if (kind < 95) begin
            // around the store size, some over it
            len = $urandom_range(58, 70);
            for (int k = 0; k < len; k++) begin
               if (k % 7 == 0) p.push_back(pcc_pkg::CH_SLASH);
               else p.push_back(8'(8'h61 + $urandom_range(0, 25)));
            end
         end else begin
            p = deep_path($urandom_range(1, 8));
         end
         send_path(p);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
